// ===== design/ckreasm_pkg.sv =====
// ----------------------------------------------------------------------------
// ckreasm_pkg
// Shared types, constants and the CRC-16/CCITT-FALSE byte update for the
// chunk reassembler.
// ----------------------------------------------------------------------------
package ckreasm_pkg;

   localparam int PAYLOAD_BYTES_DEF = 512;

   localparam int READ_INDEX_W  = 9;
   localparam int PAYLOAD_LEN_W = 10;
   localparam int POS_W         = 11;

   localparam logic [POS_W-1:0] POS_MAX  = 11'd2047;
   localparam logic [POS_W-1:0] HDR_LEN  = 11'd7;
   localparam logic [POS_W-1:0] HDR_LAST = 11'd6;
   localparam int               HDR_STORE = 6;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   localparam logic KIND_CHUNK = 1'b0;
   localparam logic KIND_READ  = 1'b1;

   typedef enum logic [2:0] {
      ST_MORE     = 3'd0,
      ST_COMPLETE = 3'd1,
      ST_SHORT    = 3'd2,
      ST_UNEXP    = 3'd3,
      ST_OVERFLOW = 3'd4,
      ST_CRC_BAD  = 3'd5,
      ST_READ_OK  = 3'd6,
      ST_READ_OOR = 3'd7
   } status_type;

   typedef struct packed {
      logic                    kind;
      logic [7:0]              data_byte;
      logic                    last_of_chunk;
      logic [READ_INDEX_W-1:0] read_index;
   } req_type;

   typedef struct packed {
      status_type               status;
      logic [7:0]               message_type;
      logic [PAYLOAD_LEN_W-1:0] payload_length;
      logic [7:0]               read_data;
   } rsp_type;

   // per-transaction control from the engine to the result stage
   typedef struct packed {
      logic has_result;
      logic read_ok;
   } step_type;

   // message-level reassembly state (stored length is kept apart, it is sized
   // by the payload depth)
   typedef struct packed {
      logic        active;
      logic [7:0]  held_type;
      logic [15:0] total_count;
      logic [15:0] next_index;
      logic [15:0] expected_check;
      logic [15:0] running_check;
   } reasm_type;

   localparam reasm_type MSG_CLEAR = '{
      active:         1'b0,
      held_type:      8'd0,
      total_count:    16'd0,
      next_index:     16'd0,
      expected_check: 16'd0,
      running_check:  CRC_INIT
   };

   function automatic logic [15:0] crc_byte(input logic [15:0] crc_i, input logic [7:0] b);
      logic [15:0] c;
      c = crc_i ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== design/ckreasm_ram.sv =====
// ----------------------------------------------------------------------------
// ckreasm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ckreasm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

// ===== design/ckreasm_engine.sv =====
// ----------------------------------------------------------------------------
// ckreasm_engine
// Reassembly state and the combinational update for one transaction: header
// check, payload store write, CRC update, chunk completion status and read status.
// ----------------------------------------------------------------------------
module ckreasm_engine #(
   parameter int PAYLOAD_BYTES = ckreasm_pkg::PAYLOAD_BYTES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             fire,
   input  ckreasm_pkg::req_type             item,
   output ckreasm_pkg::rsp_type             res,
   output ckreasm_pkg::step_type            step,
   output logic                             ram_wr_en,
   output logic [$clog2(PAYLOAD_BYTES)-1:0] ram_wr_addr,
   output logic [7:0]                       ram_wr_data,
   output logic                             ram_rd_en,
   output logic [$clog2(PAYLOAD_BYTES)-1:0] ram_rd_addr
);

   localparam int ADDR_W = $clog2(PAYLOAD_BYTES);
   localparam int LEN_W  = $clog2(PAYLOAD_BYTES + 1);
   localparam int CMP_W  = (LEN_W > ckreasm_pkg::READ_INDEX_W) ?
                           LEN_W : ckreasm_pkg::READ_INDEX_W;

   ckreasm_pkg::reasm_type          msg_ff, msg_in;
   logic [LEN_W-1:0]                len_ff, len_in;
   logic [ckreasm_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic                            rej_ff, rej_in;
   logic [7:0]                      hdr_ff [ckreasm_pkg::HDR_STORE];
   logic [7:0]                      hdr_in [ckreasm_pkg::HDR_STORE];

   always_ff @(posedge clock) begin
      if (reset) begin
         msg_ff <= ckreasm_pkg::MSG_CLEAR;
         len_ff <= '0;
         pos_ff <= '0;
         rej_ff <= 1'b0;
      end else if (fire) begin
         msg_ff <= msg_in;
         len_ff <= len_in;
         pos_ff <= pos_in;
         rej_ff <= rej_in;
      end
   end

   // header bytes are always rewritten before the header check reads them
   always_ff @(posedge clock) begin
      if (fire) begin
         hdr_ff <= hdr_in;
      end
   end

   always_comb begin
      logic [7:0]  h_type;
      logic [15:0] h_idx;
      logic [15:0] h_tot;
      logic [15:0] h_chk;
      logic        read_hit;
      logic        rej_now;

      h_type   = hdr_ff[0];
      h_idx    = {hdr_ff[2], hdr_ff[1]};
      h_tot    = {hdr_ff[4], hdr_ff[3]};
      h_chk    = {item.data_byte, hdr_ff[5]};
      read_hit = CMP_W'(item.read_index) < CMP_W'(len_ff);

      msg_in  = msg_ff;
      len_in  = len_ff;
      pos_in  = pos_ff;
      rej_in  = rej_ff;
      hdr_in  = hdr_ff;
      rej_now = rej_ff;

      step            = '0;
      res             = '0;
      res.status      = ckreasm_pkg::ST_MORE;
      ram_wr_en       = 1'b0;
      ram_wr_addr     = ADDR_W'(len_ff);
      ram_wr_data     = item.data_byte;
      ram_rd_en       = fire && (item.kind == ckreasm_pkg::KIND_READ);
      ram_rd_addr     = ADDR_W'(item.read_index);

      if (item.kind == ckreasm_pkg::KIND_READ) begin
         step.has_result = 1'b1;
         step.read_ok    = read_hit;
         res.status      = read_hit ? ckreasm_pkg::ST_READ_OK : ckreasm_pkg::ST_READ_OOR;
      end else begin
         if (pos_ff != ckreasm_pkg::POS_MAX) begin
            pos_in = pos_ff + ckreasm_pkg::POS_W'(1);
         end

         if (pos_ff < ckreasm_pkg::HDR_LEN) begin
            if (pos_ff < ckreasm_pkg::HDR_LAST) begin
               hdr_in[pos_ff[2:0]] = item.data_byte;
            end
            if (pos_ff == ckreasm_pkg::HDR_LAST) begin
               // index zero restarts the message from this header
               if (h_idx == 16'd0) begin
                  msg_in                = ckreasm_pkg::MSG_CLEAR;
                  len_in                = '0;
                  msg_in.total_count    = h_tot;
                  msg_in.expected_check = h_chk;
                  msg_in.held_type      = h_type;
                  msg_in.active         = 1'b1;
               end
               if (!msg_in.active || h_idx != msg_in.next_index ||
                   h_tot != msg_in.total_count || h_chk != msg_in.expected_check ||
                   h_type != msg_in.held_type) begin
                  msg_in  = ckreasm_pkg::MSG_CLEAR;
                  len_in  = '0;
                  rej_now = 1'b1;
               end
            end
         end else if (!rej_ff && msg_ff.active) begin
            if (len_ff < LEN_W'(PAYLOAD_BYTES)) begin
               ram_wr_en            = fire;
               msg_in.running_check = ckreasm_pkg::crc_byte(msg_ff.running_check,
                                                            item.data_byte);
               len_in               = len_ff + LEN_W'(1);
            end else begin
               msg_in = ckreasm_pkg::MSG_CLEAR;
               len_in = '0;
            end
         end

         rej_in = rej_now;

         if (item.last_of_chunk) begin
            step.has_result = 1'b1;
            pos_in          = '0;
            rej_in          = 1'b0;
            if (pos_ff < ckreasm_pkg::HDR_LAST) begin
               msg_in     = ckreasm_pkg::MSG_CLEAR;
               len_in     = '0;
               res.status = ckreasm_pkg::ST_SHORT;
            end else if (rej_now) begin
               res.status = ckreasm_pkg::ST_UNEXP;
            end else if (!msg_in.active) begin
               res.status = ckreasm_pkg::ST_OVERFLOW;
            end else begin
               msg_in.next_index = msg_in.next_index + 16'd1;
               if (msg_in.next_index < msg_in.total_count) begin
                  res.status = ckreasm_pkg::ST_MORE;
               end else if (msg_in.running_check != msg_in.expected_check) begin
                  msg_in     = ckreasm_pkg::MSG_CLEAR;
                  len_in     = '0;
                  res.status = ckreasm_pkg::ST_CRC_BAD;
               end else begin
                  res.status = ckreasm_pkg::ST_COMPLETE;
               end
            end
         end
      end

      res.message_type   = msg_in.held_type;
      res.payload_length = ckreasm_pkg::PAYLOAD_LEN_W'(len_in);
   end

endmodule

// ===== design/chunk_reassembler_crc16.sv =====
// ----------------------------------------------------------------------------
// chunk_reassembler_crc16
// Reassembles framed chunks into a payload store, checked by CRC-16/CCITT-FALSE.
// ----------------------------------------------------------------------------
// Throughput is one transaction per clock while the result side is not stalled;
// each transaction goes through an input register and then a result register,
// which presents the result. The rate is set by the byte-wise CRC update and
// the single write port of the payload RAM. A stall on the result side holds
// the whole pipeline. Only the last byte of a chunk and read transactions
// produce a result. The payload RAM needs no clearing after reset: only data
// from positions below the stored length is ever returned.
module chunk_reassembler_crc16 #(
   parameter int PAYLOAD_BYTES = ckreasm_pkg::PAYLOAD_BYTES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ckreasm_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ckreasm_pkg::rsp_type rsp_data
);

   localparam int ADDR_W = $clog2(PAYLOAD_BYTES);

   logic                  s1_valid_ff, s1_valid_in;
   ckreasm_pkg::req_type  s1_data_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   ckreasm_pkg::rsp_type  rsp_ff;
   logic                  rd_sel_ff;

   logic                  advance;
   logic                  fire;
   ckreasm_pkg::rsp_type  eng_res;
   ckreasm_pkg::step_type eng_step;
   logic                  ram_wr_en;
   logic [ADDR_W-1:0]     ram_wr_addr;
   logic [7:0]            ram_wr_data;
   logic                  ram_rd_en;
   logic [ADDR_W-1:0]     ram_rd_addr;
   logic [7:0]            ram_rd_data;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign fire      = s1_valid_ff && advance;
   assign req_ready = !s1_valid_ff || advance;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_valid && req_ready) begin
         s1_valid_in = 1'b1;
      end else if (fire) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = advance ? (fire && eng_step.has_result) : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_data_ff <= req_data;
      end
      if (fire) begin
         rsp_ff    <= eng_res;
         rd_sel_ff <= eng_step.read_ok;
      end
   end

   ckreasm_engine #(
      .PAYLOAD_BYTES(PAYLOAD_BYTES)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .item        (s1_data_ff),
      .res         (eng_res),
      .step        (eng_step),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr)
   );

   ckreasm_ram #(
      .WIDTH(8),
      .DEPTH(PAYLOAD_BYTES)
   ) u_payload_ram (
      .clock      (clock),
      .wr_en      (ram_wr_en),
      .wr_addr    (ram_wr_addr),
      .wr_data    (ram_wr_data),
      .rd_en      (ram_rd_en),
      .rd_addr    (ram_rd_addr),
      .rd_data_ff (ram_rd_data)
   );

   // read data holds in the RAM output register while the result stalls
   always_comb begin
      rsp_data           = rsp_ff;
      rsp_data.read_data = rd_sel_ff ? ram_rd_data : 8'd0;
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for chunk_reassembler_crc16. A transaction-level
// predictor tracks the message state, CRC and payload store, and queues the
// response expected for every chunk-final byte and every read. Stimulus is a
// set of directed cases, then random framed messages with faults, noise and
// payload reads. The sender idles in bursts and the receiver stalls in
// changing patterns, with one long hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_BYTES   = ckreasm_pkg::PAYLOAD_BYTES_DEF;
   localparam int RANDOM_ITEMS  = 100;
   localparam int HDR_BYTES     = 7;
   localparam int COUNT_CEILING = 2047;

   typedef enum int {
      MSG_CLEAN,
      MSG_BAD_CRC,
      MSG_SKIP_INDEX,
      MSG_FIELD_CHANGE,
      MSG_CUT_HEADER,
      MSG_STOP_EARLY
   } msg_fault_type;

   typedef enum int {
      RX_ALWAYS,
      RX_HALF,
      RX_SPARSE,
      RX_EVERY_THIRD
   } rx_mode_type;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   ckreasm_pkg::req_type req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   ckreasm_pkg::rsp_type rsp_data;

   chunk_reassembler_crc16 DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------- predictor
   logic        asm_active;
   logic [7:0]  asm_type;
   logic [15:0] asm_total;
   logic [15:0] asm_next;
   logic [15:0] asm_crc_want;
   logic [15:0] asm_crc_run;
   int unsigned asm_len;
   int unsigned chunk_pos;
   logic [7:0]  chunk_hdr [HDR_BYTES];
   logic        chunk_dropped;
   logic [7:0]  payload_mem [STORE_BYTES];

   ckreasm_pkg::rsp_type awaited_rsp [$];
   int unsigned          mismatches;

   function automatic logic [15:0] crc16_ccitt_step(input logic [15:0] crc_in,
                                                    input logic [7:0] b);
      logic [15:0] c;
      logic        fb;
      c = crc_in;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ b[i];
         c  = {c[14:0], 1'b0};
         if (fb) begin
            c = c ^ ckreasm_pkg::CRC_POLY;
         end
      end
      return c;
   endfunction

   function automatic void clear_reassembly();
      asm_active   = 1'b0;
      asm_type     = 8'd0;
      asm_total    = 16'd0;
      asm_next     = 16'd0;
      asm_crc_want = 16'd0;
      asm_crc_run  = ckreasm_pkg::CRC_INIT;
      asm_len      = 0;
   endfunction

   function automatic void check_chunk_header();
      logic [15:0] idx;
      logic [15:0] tot;
      logic [15:0] chk;
      idx = {chunk_hdr[2], chunk_hdr[1]};
      tot = {chunk_hdr[4], chunk_hdr[3]};
      chk = {chunk_hdr[6], chunk_hdr[5]};
      if (idx == 16'd0) begin
         clear_reassembly();
         asm_total    = tot;
         asm_crc_want = chk;
         asm_type     = chunk_hdr[0];
         asm_active   = 1'b1;
      end
      if (!asm_active || idx != asm_next || tot != asm_total ||
          chk != asm_crc_want || chunk_hdr[0] != asm_type) begin
         clear_reassembly();
         chunk_dropped = 1'b1;
      end
   endfunction

   function automatic ckreasm_pkg::status_type chunk_end_status(input int unsigned pos);
      if (pos < HDR_BYTES - 1) begin
         clear_reassembly();
         return ckreasm_pkg::ST_SHORT;
      end
      if (chunk_dropped) return ckreasm_pkg::ST_UNEXP;
      if (!asm_active) return ckreasm_pkg::ST_OVERFLOW;
      asm_next = asm_next + 16'd1;
      if (asm_next < asm_total) return ckreasm_pkg::ST_MORE;
      if (asm_crc_run != asm_crc_want) begin
         clear_reassembly();
         return ckreasm_pkg::ST_CRC_BAD;
      end
      return ckreasm_pkg::ST_COMPLETE;
   endfunction

   function automatic void predict_transaction(input ckreasm_pkg::req_type t);
      ckreasm_pkg::rsp_type r;
      logic                 emit;
      int unsigned          pos;
      r    = '0;
      emit = 1'b0;
      if (t.kind == ckreasm_pkg::KIND_READ) begin
         emit = 1'b1;
         if (t.read_index < asm_len) begin
            r.status    = ckreasm_pkg::ST_READ_OK;
            r.read_data = payload_mem[t.read_index];
         end else begin
            r.status = ckreasm_pkg::ST_READ_OOR;
         end
      end else begin
         pos = chunk_pos;
         if (chunk_pos < COUNT_CEILING) chunk_pos++;
         if (pos < HDR_BYTES) begin
            chunk_hdr[pos] = t.data_byte;
            if (pos == HDR_BYTES - 1) check_chunk_header();
         end else if (!chunk_dropped && asm_active) begin
            if (asm_len < STORE_BYTES) begin
               payload_mem[asm_len] = t.data_byte;
               asm_crc_run = crc16_ccitt_step(asm_crc_run, t.data_byte);
               asm_len++;
            end else begin
               clear_reassembly();
            end
         end
         if (t.last_of_chunk) begin
            emit          = 1'b1;
            r.status      = chunk_end_status(pos);
            chunk_pos     = 0;
            chunk_dropped = 1'b0;
         end
      end
      if (emit) begin
         r.message_type   = asm_type;
         r.payload_length = asm_len[ckreasm_pkg::PAYLOAD_LEN_W-1:0];
         awaited_rsp.push_back(r);
      end
   endfunction

   // ---------------------------------------------------------------- checker
   always @(posedge clock) begin : rsp_check
      ckreasm_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_rsp.size() == 0) begin
            if (mismatches < 10) begin
               $display("%0t: unexpected response status=%0d type=%0h len=%0d data=%0h",
                        $realtime, rsp_data.status, rsp_data.message_type,
                        rsp_data.payload_length, rsp_data.read_data);
            end
            mismatches++;
         end else begin
            want = awaited_rsp.pop_front();
            if (rsp_data.status !== want.status ||
                rsp_data.message_type !== want.message_type ||
                rsp_data.payload_length !== want.payload_length ||
                rsp_data.read_data !== want.read_data) begin
               if (mismatches < 10) begin
                  $display("%0t: mismatch exp status=%0d type=%0h len=%0d data=%0h",
                           $realtime, want.status, want.message_type,
                           want.payload_length, want.read_data);
                  $display("%0t:          got status=%0d type=%0h len=%0d data=%0h",
                           $realtime, rsp_data.status, rsp_data.message_type,
                           rsp_data.payload_length, rsp_data.read_data);
               end
               mismatches++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- receiver
   int unsigned hold_req;
   int unsigned hold_left;
   int unsigned rx_cycles;
   rx_mode_type rx_mode = RX_ALWAYS;

   always @(posedge clock) begin
      rx_cycles++;
      if (hold_req != 0) begin
         hold_left = hold_req;
         hold_req  = 0;
      end
      if (rx_cycles % 300 == 0) rx_mode = rx_mode_type'($urandom_range(3, 0));
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         case (rx_mode)
            RX_ALWAYS:  rsp_ready <= 1'b1;
            RX_HALF:    rsp_ready <= ($urandom_range(1, 0) == 1);
            RX_SPARSE:  rsp_ready <= ($urandom_range(3, 0) == 0);
            default:    rsp_ready <= (rx_cycles % 3 == 0);
         endcase
      end
   end

   // ---------------------------------------------------------------- sender
   logic        gaps_on = 1'b1;
   logic        counting = 1'b1;
   int unsigned burst_left;
   int unsigned useful_count;
   int unsigned read_mix;
   logic [7:0]  chunk_buf [$];
   logic [7:0]  msg_body [$];
   logic [7:0]  last_type;
   logic [15:0] last_total;
   logic [15:0] last_crc_field;

   function automatic ckreasm_pkg::req_type make_req(input logic kind, input logic [7:0] b,
                                                     input logic last,
                                                     input logic [8:0] ridx);
      ckreasm_pkg::req_type t;
      t.kind          = kind;
      t.data_byte     = b;
      t.last_of_chunk = last;
      t.read_index    = ridx;
      return t;
   endfunction

   // valid stays high across a burst; next call lands in the same time step
   task automatic send_item(input ckreasm_pkg::req_type t);
      if (burst_left == 0) begin
         burst_left = $urandom_range(24, 1);
         if (gaps_on && $urandom_range(3, 0) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_transaction(t);
      if (counting) useful_count++;
   endtask

   task automatic send_read(input logic [8:0] ridx);
      send_item(make_req(ckreasm_pkg::KIND_READ, 8'($urandom_range(255, 0)),
                         1'($urandom_range(1, 0)), ridx));
   endtask

   function automatic logic [8:0] pick_read_index();
      int unsigned sel;
      sel = $urandom_range(7, 0);
      if (asm_len > 0 && sel < 5) return 9'($urandom_range(asm_len - 1, 0));
      if (sel == 5 && asm_len < STORE_BYTES) return 9'(asm_len);
      return 9'($urandom_range(511, 0));
   endfunction

   task automatic send_chunk_buf();
      int unsigned n;
      n = chunk_buf.size();
      for (int i = 0; i < n; i++) begin
         if (read_mix != 0 && $urandom_range(read_mix - 1, 0) == 0) begin
            send_read(pick_read_index());
         end
         send_item(make_req(ckreasm_pkg::KIND_CHUNK, chunk_buf[i], (i == n - 1),
                            9'($urandom_range(511, 0))));
      end
   endtask

   function automatic void push_header(input logic [7:0] typ, input logic [15:0] idx,
                                       input logic [15:0] tot, input logic [15:0] chk);
      chunk_buf.push_back(typ);
      chunk_buf.push_back(idx[7:0]);
      chunk_buf.push_back(idx[15:8]);
      chunk_buf.push_back(tot[7:0]);
      chunk_buf.push_back(tot[15:8]);
      chunk_buf.push_back(chk[7:0]);
      chunk_buf.push_back(chk[15:8]);
   endfunction

   // Frames a random payload into n_chunks chunks, optionally breaking one.
   task automatic send_message(input logic [7:0] typ, input int n_chunks,
                               input int n_body, input msg_fault_type fault);
      logic [15:0] crc;
      logic [15:0] total;
      logic [15:0] idx;
      logic [15:0] tot;
      logic [15:0] chk;
      logic [7:0]  typ_c;
      int          bad_chunk;
      int          remaining;
      int          offset;
      int          len;
      msg_body.delete();
      crc = ckreasm_pkg::CRC_INIT;
      for (int i = 0; i < n_body; i++) begin
         msg_body.push_back(8'($urandom_range(255, 0)));
         crc = crc16_ccitt_step(crc, msg_body[i]);
      end
      total = (n_chunks == 1 && $urandom_range(1, 0) == 0) ? 16'd0 : 16'(n_chunks);
      if (fault == MSG_BAD_CRC) crc = crc ^ 16'($urandom_range(16'hFFFF, 1));
      last_type      = typ;
      last_total     = total;
      last_crc_field = crc;
      bad_chunk = $urandom_range(n_chunks - 1, 0);
      remaining = n_body;
      offset    = 0;
      for (int c = 0; c < n_chunks; c++) begin
         if (fault == MSG_STOP_EARLY && c == bad_chunk && c > 0) break;
         if (c == n_chunks - 1) begin
            len = remaining;
         end else begin
            len = $urandom_range(2 * remaining / (n_chunks - c), 0);
            if (len > remaining) len = remaining;
         end
         idx   = 16'(c);
         tot   = total;
         chk   = crc;
         typ_c = typ;
         if (c == bad_chunk && fault == MSG_SKIP_INDEX) idx = idx + 16'd1;
         if (c == bad_chunk && fault == MSG_FIELD_CHANGE) begin
            case ($urandom_range(2, 0))
               0:       typ_c = typ_c ^ (8'd1 << $urandom_range(7, 0));
               1:       tot   = tot ^ (16'd1 << $urandom_range(15, 0));
               default: chk   = chk ^ (16'd1 << $urandom_range(15, 0));
            endcase
         end
         chunk_buf.delete();
         push_header(typ_c, idx, tot, chk);
         if (c == bad_chunk && fault == MSG_CUT_HEADER) begin
            repeat ($urandom_range(6, 1)) void'(chunk_buf.pop_back());
         end else begin
            for (int k = 0; k < len; k++) chunk_buf.push_back(msg_body[offset + k]);
         end
         send_chunk_buf();
         offset    += len;
         remaining -= len;
      end
   endtask

   task automatic send_noise_chunk();
      counting = 1'b0;
      chunk_buf.delete();
      repeat ($urandom_range(14, 1)) chunk_buf.push_back(8'($urandom_range(255, 0)));
      // sometimes a zero index, so the junk opens a message
      if (chunk_buf.size() > 2 && $urandom_range(2, 0) == 0) begin
         chunk_buf[1] = 8'd0;
         chunk_buf[2] = 8'd0;
      end
      send_chunk_buf();
      counting = 1'b1;
   endtask

   // ---------------------------------------------------------------- tests
   task automatic test_directed();
      logic [15:0] crc;
      read_mix = 0;
      send_read(9'd0);                       // nothing stored yet
      chunk_buf = {8'hFF};                   // chunk of a single byte
      send_chunk_buf();
      // single chunk, total of zero, extreme body bytes
      crc = crc16_ccitt_step(crc16_ccitt_step(ckreasm_pkg::CRC_INIT, 8'h00), 8'hFF);
      chunk_buf.delete();
      push_header(8'hFF, 16'd0, 16'd0, crc);
      chunk_buf.push_back(8'h00);
      chunk_buf.push_back(8'hFF);
      send_chunk_buf();
      send_read(9'd1);
      send_read(9'd511);
      chunk_buf = {8'h12, 8'h00, 8'h00, 8'h01, 8'h00, 8'h34};   // header cut at six
      send_chunk_buf();
      // header-only chunk with a nonzero index and nothing open
      chunk_buf.delete();
      push_header(8'h00, 16'd1, 16'd0, 16'h0000);
      send_chunk_buf();
   endtask

   task automatic test_chunk_sequences();
      read_mix = 6;
      send_message(8'h5A, 3, 24, MSG_CLEAN);
      send_message(8'h01, 2, 10, MSG_BAD_CRC);
      send_message(8'h80, 3, 12, MSG_SKIP_INDEX);
      send_message(8'h7F, 3, 9, MSG_FIELD_CHANGE);
      send_message(8'hC3, 2, 6, MSG_CUT_HEADER);
      send_message(8'h44, 4, 16, MSG_STOP_EARLY);
      send_message(8'h00, 1, 0, MSG_CLEAN);
      send_message(8'h99, 2, 0, MSG_CLEAN);
   endtask

   task automatic test_store_limits();
      read_mix = 16;
      send_message(8'hA5, 2, STORE_BYTES, MSG_CLEAN);
      send_read(9'd511);
      send_read(9'd0);
      // next chunk of the finished message; its first body byte finds the store full
      chunk_buf.delete();
      push_header(last_type, 16'd2, last_total, last_crc_field);
      repeat (3) chunk_buf.push_back(8'($urandom_range(255, 0)));
      send_chunk_buf();
      send_read(9'd0);
   endtask

   task automatic test_result_backpressure();
      read_mix = 4;
      gaps_on  = 1'b0;
      hold_req = 200;
      repeat (40) send_read(pick_read_index());
      send_message(8'($urandom_range(255, 0)), 2, 20, MSG_CLEAN);
      gaps_on = 1'b1;
   endtask

   task automatic test_random_traffic();
      int unsigned pick;
      int          n_body;
      useful_count = 0;
      while (useful_count < RANDOM_ITEMS) begin
         pick     = $urandom_range(9, 0);
         read_mix = $urandom_range(12, 3);
         gaps_on  = ($urandom_range(4, 0) != 0);
         n_body   = ($urandom_range(9, 0) == 0) ? $urandom_range(160, 41)
                                                 : $urandom_range(40, 0);
         if (pick < 6) begin
            send_message(8'($urandom_range(255, 0)), $urandom_range(4, 1), n_body,
                         MSG_CLEAN);
         end else if (pick < 9) begin
            send_message(8'($urandom_range(255, 0)), $urandom_range(4, 1), n_body,
                         msg_fault_type'($urandom_range(5, 1)));
         end else begin
            send_noise_chunk();
         end
      end
      gaps_on = 1'b1;
   endtask

   // ---------------------------------------------------------------- run
   initial begin
      int unsigned guard;
      clear_reassembly();
      chunk_pos     = 0;
      chunk_dropped = 1'b0;
      for (int i = 0; i < HDR_BYTES; i++) chunk_hdr[i] = 8'd0;
      mismatches = 0;
      burst_left = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_chunk_sequences();
      test_store_limits();
      test_result_backpressure();
      test_random_traffic();

      req_valid <= 1'b0;
      guard = 0;
      while (awaited_rsp.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (10) @(posedge clock);

      if (mismatches == 0 && awaited_rsp.size() == 0) begin
         $display("PASS");
      end else begin
         if (awaited_rsp.size() != 0) begin
            $display("%0d responses never arrived", awaited_rsp.size());
         end
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

// ===== chunk_reassembler_crc16.f =====
design/ckreasm_pkg.sv
design/ckreasm_ram.sv
design/ckreasm_engine.sv
design/chunk_reassembler_crc16.sv
sim/tb_top.sv
